// File: src/cfrd_pkg.sv
// Shared types and constants for the COBS frame receiver and decoder.
package cfrd_pkg;

  // Frame layout: zero, id, first code, size, payload, check byte
  localparam logic [8:0] ID_POS         = 9'd1;
  localparam logic [8:0] FIRST_CODE_POS = 9'd2;
  localparam logic [8:0] SIZE_POS       = 9'd3;
  // Added to the payload size to give the check byte position (overhead less one)
  localparam logic [8:0] LAST_OFFSET    = 9'd4;

  typedef logic [8:0] pos_t;
  typedef logic [9:0] code_pos_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] data_byte;
    logic [7:0] frame_id;
    logic [7:0] payload_length;
  } result_t;

endpackage

// File: src/cfrd_in_reg.sv
// Input register stage: holds one received word until the decoder takes it.
module cfrd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);
  import cfrd_pkg::*;

  // Take a new word when empty or when the held word moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

// File: src/cfrd_core.sv
// Frame tracking and stuffing-code decode for one received word per cycle while advance is high.
module cfrd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  output logic              has_result,
  output cfrd_pkg::result_t result
);
  import cfrd_pkg::*;

  pos_t       byte_position, byte_position_next;
  code_pos_t  next_code_position, next_code_position_next;
  logic [7:0] held_message_id, held_message_id_next;
  logic [7:0] held_payload_size, held_payload_size_next;
  logic       at_code;
  pos_t       last_pos;
  pos_t       pos_inc;

  assign at_code  = ({1'b0, byte_position} == next_code_position);
  assign last_pos = {1'b0, held_payload_size} + LAST_OFFSET;
  assign pos_inc  = byte_position + 9'd1;

  // Decode the word against the frame position and the code chain
  always_comb begin
    byte_position_next      = byte_position;
    next_code_position_next = next_code_position;
    held_message_id_next    = held_message_id;
    held_payload_size_next  = held_payload_size;
    has_result              = 1'b0;
    result.frame_end        = 1'b0;
    result.data_byte        = rx_byte;
    result.frame_id         = held_message_id;
    result.payload_length   = held_payload_size;
    if (rx_byte == 8'd0) begin
      // Zero opens a frame, abandoning any frame in progress
      byte_position_next      = ID_POS;
      next_code_position_next = {1'b0, FIRST_CODE_POS};
      held_message_id_next    = 8'd0;
      held_payload_size_next  = 8'd0;
    end else if (byte_position != '0) begin
      if (at_code) begin
        next_code_position_next = next_code_position + {2'b00, rx_byte};
      end
      if (byte_position == ID_POS) begin
        held_message_id_next = rx_byte;
        byte_position_next   = pos_inc;
      end else if (byte_position == FIRST_CODE_POS) begin
        byte_position_next = pos_inc;
      end else if (byte_position == SIZE_POS) begin
        // A first code of one marks an empty payload
        held_payload_size_next = at_code ? 8'd0 : rx_byte;
        byte_position_next     = pos_inc;
      end else if (byte_position >= last_pos) begin
        has_result         = 1'b1;
        result.frame_end   = 1'b1;
        byte_position_next = '0;
      end else begin
        has_result         = 1'b1;
        result.data_byte   = at_code ? 8'd0 : rx_byte;
        byte_position_next = pos_inc;
      end
    end
  end

  // Advance frame state when the word is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      next_code_position <= '0;
      held_message_id    <= '0;
      held_payload_size  <= '0;
    end else if (advance) begin
      byte_position      <= byte_position_next;
      next_code_position <= next_code_position_next;
      held_message_id    <= held_message_id_next;
      held_payload_size  <= held_payload_size_next;
    end
  end

endmodule

// File: src/cfrd_out_reg.sv
// Result register: holds one decoded word until the consumer takes it.
module cfrd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cfrd_pkg::result_t load_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cfrd_pkg::result_t out_data
);
  import cfrd_pkg::*;

  // Set on load, clear once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// File: src/cobs_frame_receiver_decoder.sv
// Top level of the COBS frame receiver and decoder.
// Takes one link byte per cycle and gives at most one result word per byte:
// a decoded payload byte (frame_end low) or, on the check byte, the raw check
// byte with frame_end high, each tagged with the frame's id and payload length.
// A byte passes an input register and then the decode logic into the result
// register, and its word appears on the output once the result register has
// loaded it; one byte is accepted every cycle while out_ready stays high.
// Nonzero bytes outside a frame and the id, first code and size bytes give no
// result; a zero byte always starts a new frame. The check byte is not verified.
module cobs_frame_receiver_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       frame_end,
  output logic [7:0] data_byte,
  output logic [7:0] frame_id,
  output logic [7:0] payload_length
);
  import cfrd_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       has_result;
  logic       advance;
  result_t    result;
  result_t    out_data;

  // Move a held word on unless its result would overwrite an untaken one
  assign advance = held_valid && (!has_result || !out_valid || out_ready);

  cfrd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  cfrd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .rx_byte    (held_byte),
    .has_result (has_result),
    .result     (result)
  );

  cfrd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .load_data (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign frame_end      = out_data.frame_end;
  assign data_byte      = out_data.data_byte;
  assign frame_id       = out_data.frame_id;
  assign payload_length = out_data.payload_length;

endmodule
